@@ rtl/bsp_pkg.sv @@
// shared constants, codes and types for the bounded stack with palindrome check
// no dependencies; used by the channel interfaces and every module of the block
package bsp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 8;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DEPTH_NOW_W     = 4;

  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic [DEPTH_NOW_W-1:0]     depth_now_t;

  // operation codes
  localparam kind_t KIND_PUSH  = 2'd0;
  localparam kind_t KIND_POP   = 2'd1;
  localparam kind_t KIND_CHECK = 2'd2;

  // result status codes
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the request word this cycle
    logic chk_step;  // one step of the palindrome walk
    logic load_out;  // load the response register
  } bsp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done; // all pairs issued, last compare lands this cycle
  } bsp_sts_t;

endpackage

@@ rtl/bsp_ifs.sv @@
// valid/ready channel interfaces for request and response words
// depends on bsp_pkg for field types
interface bsp_req_if;
  logic            valid;
  logic            ready;
  bsp_pkg::kind_t  kind;
  bsp_pkg::word_t  push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface bsp_rsp_if;
  logic                 valid;
  logic                 ready;
  bsp_pkg::status_t     status;
  bsp_pkg::word_t       popped_value;
  logic                 is_palindrome;
  bsp_pkg::depth_now_t  depth_now;

  modport source (output valid, output status, output popped_value,
                  output is_palindrome, output depth_now, input ready);
  modport sink   (input valid, input status, input popped_value,
                  input is_palindrome, input depth_now, output ready);
endinterface

@@ rtl/bounded_stack_with_palindrome_check_unit.sv @@
// top level of the bounded stack with palindrome check
// depends on bsp_pkg, bsp_ifs, bsp_ctrl and bsp_datapath
//
// bounded lifo stack of STACK_DEPTH signed 32-bit words; each request word
// carries an operation (push, pop, palindrome check) and yields exactly one
// response word with a status, the popped word, the palindrome flag and the
// fill level after the operation. one request is worked at a time: push, pop
// and the unused code go from acceptance straight to the finish state, while
// a palindrome check first walks the stored words in the check state; the
// storage has two read ports and the walk compares one mirrored pair per
// cycle. in the finish state the response register loads once the output
// register is free, and response valid rises with that load. the finished
// response sits in an output register, so a stalled consumer holds up only
// the next completion, not the acceptance of the next request. no clearing
// pass is needed after reset.
module bounded_stack_with_palindrome_check_unit
  import bsp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bsp_req_if.sink   req,
  bsp_rsp_if.source rsp
);

  // controller/datapath handshake
  bsp_cmd_t   cmd;
  bsp_sts_t   sts;

  // response payload from the datapath register
  status_t    res_status;
  word_t      res_popped;
  logic       res_pal;
  depth_now_t res_depth;

  // sequencer: owns request ready and response valid
  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage, fill count, pair compare and response payload
  bsp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (req.kind),
    .push_value    (req.push_value),
    .status        (res_status),
    .popped_value  (res_popped),
    .is_palindrome (res_pal),
    .depth_now     (res_depth)
  );

  assign rsp.status        = res_status;
  assign rsp.popped_value  = res_popped;
  assign rsp.is_palindrome = res_pal;
  assign rsp.depth_now     = res_depth;

endmodule

@@ rtl/bsp_datapath.sv @@
// stack storage, fill count, palindrome walk and response register
// depends on bsp_pkg; driven by bsp_ctrl commands
module bsp_datapath
  import bsp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  bsp_cmd_t   cmd,
  output bsp_sts_t   sts,
  input  kind_t      kind,
  input  word_t      push_value,
  output status_t    status,
  output word_t      popped_value,
  output logic       is_palindrome,
  output depth_now_t depth_now
);

  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  word_t mem [STACK_DEPTH];

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          cmp_valid;
  logic          match;
  kind_t         kind_q;
  status_t       status_q;
  logic          pop_ok;
  word_t         rd_a;
  word_t         rd_b;

  logic          full;
  logic          empty;
  logic [CW-1:0] half;
  logic [CW-1:0] top_idx;
  logic [CW-1:0] mirror_idx;
  logic [IW-1:0] addr_a;
  logic [IW-1:0] addr_b;
  logic          rd_en;
  logic [CW+DEPTH_NOW_W-1:0] count_ext;

  assign full       = (count >= DEPTH_C);
  assign empty      = (count == '0);
  assign half       = count >> 1;
  assign top_idx    = count - ONE_C;
  assign mirror_idx = top_idx - idx;
  assign addr_a     = cmd.accept ? top_idx[IW-1:0] : idx[IW-1:0];
  assign addr_b     = mirror_idx[IW-1:0];
  assign rd_en      = (cmd.accept && kind == KIND_POP && !empty) ||
                      (cmd.chk_step && idx < half);
  assign count_ext  = {{DEPTH_NOW_W{1'b0}}, count};
  assign sts.walk_done = (idx >= half);

  // storage write port
  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_PUSH && !full) begin
      mem[count[IW-1:0]] <= push_value;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
      match     <= 1'b1;
      kind_q    <= KIND_PUSH;
      status_q  <= ST_DONE;
      pop_ok    <= 1'b0;
    end else if (cmd.accept) begin
      kind_q    <= kind;
      pop_ok    <= (kind == KIND_POP) && !empty;
      idx       <= '0;
      cmp_valid <= 1'b0;
      match     <= 1'b1;
      if (kind == KIND_PUSH && full) begin
        status_q <= ST_FULL;
      end else if (kind == KIND_POP && empty) begin
        status_q <= ST_EMPTY;
      end else begin
        status_q <= ST_DONE;
      end
      case (kind)
        KIND_PUSH: begin
          if (!full) begin
            count <= count + ONE_C;
          end
        end
        KIND_POP: begin
          if (!empty) begin
            count <= top_idx;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.chk_step) begin
      if (cmp_valid && rd_a != rd_b) begin
        match <= 1'b0;
      end
      if (idx < half) begin
        idx       <= idx + ONE_C;
        cmp_valid <= 1'b1;
      end else begin
        cmp_valid <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= status_q;
      popped_value  <= pop_ok ? rd_a : '0;
      is_palindrome <= (kind_q == KIND_CHECK) ? match : 1'b0;
      depth_now     <= count_ext[DEPTH_NOW_W-1:0];
    end
  end

endmodule

@@ rtl/bsp_ctrl.sv @@
// sequencing controller: request handshake, palindrome walk, response valid
// depends on bsp_pkg; commands bsp_datapath
module bsp_ctrl
  import bsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  kind_t    req_kind,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output bsp_cmd_t cmd,
  input  bsp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state;

  assign req_ready    = (state == S_IDLE);
  assign cmd.accept   = (state == S_IDLE) && req_valid;
  assign cmd.chk_step = (state == S_CHECK);
  assign cmd.load_out = (state == S_FINISH) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= (req_kind == KIND_CHECK) ? S_CHECK : S_FINISH;
          end
        end
        S_CHECK: begin
          if (sts.walk_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_bounded_stack_with_palindrome_check_unit.sv @@
// self-checking testbench for bounded_stack_with_palindrome_check_unit
// depends on bsp_pkg, bsp_ifs and the rtl of the block; a scoreboard class
// tracks the stack contents and checks every response word against its prediction
module tb_bounded_stack_with_palindrome_check_unit
  import bsp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TB_DEPTH    = STACK_DEPTH_DEF;
  localparam int unsigned RANDOM_REQS = 650;
  // worst item: check walk plus a long receiver stall plus a sender gap,
  // taken many times over
  localparam int unsigned CYCLE_LIMIT = 400000;
  // the code that no operation uses; the block must answer it as a no-op
  localparam kind_t KIND_UNUSED = 2'd3;

  // one predicted response word
  typedef struct packed {
    status_t    status;
    word_t      popped;
    logic       pal;
    depth_now_t depth;
  } reply_t;

  // mirror of the stack contents and the queue of response words still owed
  class stack_scoreboard;
    word_t       store [TB_DEPTH];
    int unsigned fill;
    reply_t      replies_due [$];
    int unsigned errors;
    int unsigned n_replies;
    int unsigned n_push, n_pop, n_check, n_unused;
    int unsigned n_full, n_empty, n_mirror;

    // the stored words read the same from the bottom as from the top
    function bit mirror_image();
      for (int i = 0; i < int'(fill / 2); i++) begin
        if (store[i] !== store[fill - 1 - i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // called for each accepted request word
    function void note_request(kind_t k, word_t v);
      reply_t r;
      r = '0;
      r.status = ST_DONE;
      case (k)
        KIND_PUSH: begin
          n_push++;
          if (fill >= TB_DEPTH) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            store[fill] = v;
            fill++;
          end
        end
        KIND_POP: begin
          n_pop++;
          if (fill == 0) begin
            r.status = ST_EMPTY;
            n_empty++;
          end else begin
            fill--;
            r.popped = store[fill];
          end
        end
        KIND_CHECK: begin
          n_check++;
          r.pal = mirror_image();
          if (r.pal) n_mirror++;
        end
        default: begin
          n_unused++;
        end
      endcase
      r.depth = depth_now_t'(fill);
      replies_due.push_back(r);
    endfunction

    // called for each accepted response word
    function void check_reply(status_t s, word_t p, logic pal, depth_now_t d);
      reply_t e;
      n_replies++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: response with none due: status %0d popped %0d pal %0b depth %0d",
                 $time, s, p, pal, d);
        return;
      end
      e = replies_due.pop_front();
      if (s !== e.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, e.status, s);
      end
      if (p !== e.popped) begin
        errors++;
        $display("%0t: popped_value expected %0d got %0d", $time, e.popped, p);
      end
      if (pal !== e.pal) begin
        errors++;
        $display("%0t: is_palindrome expected %0b got %0b", $time, e.pal, pal);
      end
      if (d !== e.depth) begin
        errors++;
        $display("%0t: depth_now expected %0d got %0d", $time, e.depth, d);
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  bsp_req_if req_ch ();
  bsp_rsp_if rsp_ch ();

  bounded_stack_with_palindrome_check_unit #(
    .STACK_DEPTH(TB_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  stack_scoreboard sb = new();

  int unsigned cycles;
  int          burst_left;     // words left in the current sender burst
  int unsigned gen_depth;      // fill level as the stimulus side sees it
  int unsigned n_random;       // random-phase words that do real work
  int          rx_mode;        // receiver stall pattern in force
  int          rx_mode_left;   // cycles until the pattern changes

  // 2 ns clock
  always #1 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d responses still due",
               $time, cycles, sb.pending());
      $display("tb_bounded_stack_with_palindrome_check_unit: done, errors");
      $finish;
    end
  end

  // request side monitor: every accepted word feeds the predictor
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      sb.note_request(req_ch.kind, req_ch.push_value);
    end
  end

  // response side monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_reply(rsp_ch.status, rsp_ch.popped_value, rsp_ch.is_palindrome,
                     rsp_ch.depth_now);
    end
  end

  // receiver back-pressure: when its countdown runs out the pattern switches
  // between always ready, coin flips, rare ready and a fixed duty cycle
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(0, 3);
      rx_mode_left <= $urandom_range(40, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= 1'($urandom_range(0, 1));
      2: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
      default: rsp_ch.ready <= ((cycles % 7) < 3);
    endcase
  end

  // word values: extremes and a tiny pool make equal pairs likely,
  // full-range values toggle every bit
  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      1: return word_t'($urandom_range(0, 3));
      default: return word_t'($urandom);
    endcase
  endfunction

  // drive one request word and hold it until the block takes it;
  // a gap of random length, sometimes none, opens before each new burst
  task automatic send_word(kind_t k, word_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= k;
    req_ch.push_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // keep the stimulus-side fill level in step
    if (k == KIND_PUSH && gen_depth < TB_DEPTH) gen_depth++;
    if (k == KIND_POP && gen_depth > 0) gen_depth--;
    if (k != KIND_UNUSED) n_random++;
  endtask

  // hand-picked words: empty and one-word checks, both refusals, the
  // two-word pair compare, a full mirrored stack and the unused code
  task automatic run_directed();
    send_word(KIND_CHECK, 32'sd0);           // empty stack is a palindrome
    send_word(KIND_POP, -32'sd1);            // pop refused, nothing stored
    send_word(KIND_PUSH, 32'sh8000_0000);
    send_word(KIND_CHECK, 32'sd0);           // one word is a palindrome
    send_word(KIND_PUSH, 32'sh7fff_ffff);
    send_word(KIND_CHECK, 32'sd0);           // two differing words, one pair
    send_word(KIND_POP, 32'sd0);
    send_word(KIND_POP, 32'sd0);
    send_word(KIND_UNUSED, 32'sh1234_5678);
    send_word(KIND_PUSH, -32'sd1);
    send_word(KIND_PUSH, 32'sd0);
    send_word(KIND_PUSH, 32'sh5555_5555);
    send_word(KIND_PUSH, 32'shaaaa_aaaa);
    send_word(KIND_PUSH, 32'shaaaa_aaaa);
    send_word(KIND_PUSH, 32'sh5555_5555);
    send_word(KIND_PUSH, 32'sd0);
    send_word(KIND_PUSH, -32'sd1);
    send_word(KIND_CHECK, 32'sd0);           // full mirrored stack
    send_word(KIND_PUSH, 32'sh7fff_ffff);    // refused, stack full
    send_word(KIND_UNUSED, -32'sd1);
    send_word(KIND_POP, 32'sd0);
    send_word(KIND_CHECK, 32'sd0);           // seven words, ends differ
  endtask

  // drain, build a mirrored stack of random length (sometimes with one
  // flipped bit), check it, then poke at it from the full and the top end
  task automatic run_mirror_seq();
    word_t seq [TB_DEPTH];
    int    len;
    int    idx;
    int    n_pops;
    n_pops = gen_depth;
    repeat (n_pops) send_word(KIND_POP, rand_word());
    if ($urandom_range(0, 4) == 0) send_word(KIND_POP, rand_word());
    len = ($urandom_range(0, 3) == 0) ? TB_DEPTH : $urandom_range(0, TB_DEPTH);
    for (int i = 0; i < (len + 1) / 2; i++) begin
      seq[i]           = rand_word();
      seq[len - 1 - i] = seq[i];
    end
    if (len >= 2 && $urandom_range(0, 2) == 0) begin
      idx      = $urandom_range(0, len - 1);
      seq[idx] = seq[idx] ^ (32'sd1 << $urandom_range(0, 31));
    end
    for (int i = 0; i < len; i++) send_word(KIND_PUSH, seq[i]);
    send_word(KIND_CHECK, rand_word());
    if (gen_depth == TB_DEPTH && $urandom_range(0, 1) == 0) begin
      send_word(KIND_PUSH, rand_word());
      send_word(KIND_CHECK, rand_word());
    end
    if ($urandom_range(0, 1) == 0) begin
      n_pops = $urandom_range(0, len);
      repeat (n_pops) send_word(KIND_POP, rand_word());
      send_word(KIND_CHECK, rand_word());
    end
  endtask

  // unstructured words, pushes weighted so the stack often fills
  task automatic run_noise();
    int    n;
    int    pick;
    kind_t k;
    n = $urandom_range(1, 12);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)      k = KIND_PUSH;
      else if (pick < 75) k = KIND_POP;
      else if (pick < 96) k = KIND_CHECK;
      else                k = KIND_UNUSED;
      send_word(k, rand_word());
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.kind       = KIND_PUSH;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    cycles            = 0;
    burst_left        = 0;
    gen_depth         = 0;
    n_random          = 0;
    rx_mode           = 0;
    rx_mode_left      = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    n_random = 0;
    while (n_random < RANDOM_REQS) begin
      if ($urandom_range(0, 99) < 55) run_mirror_seq();
      else                            run_noise();
    end
    req_ch.valid <= 1'b0;

    // let the last accepted word reach the predictor, drain the owed
    // responses, then watch a little longer for stray ones
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d responses never arrived", $time, sb.pending());
    end
    $display("run: %0d requests (%0d push, %0d pop, %0d check, %0d unused code), %0d responses",
             sb.n_push + sb.n_pop + sb.n_check + sb.n_unused, sb.n_push, sb.n_pop,
             sb.n_check, sb.n_unused, sb.n_replies);
    $display("run: %0d full refusals, %0d empty refusals, %0d of %0d checks found a mirror image",
             sb.n_full, sb.n_empty, sb.n_mirror, sb.n_check);
    if (sb.errors == 0) begin
      $display("tb_bounded_stack_with_palindrome_check_unit: done, clean");
    end else begin
      $display("tb_bounded_stack_with_palindrome_check_unit: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bsp_pkg.sv
rtl/bsp_ifs.sv
rtl/bsp_datapath.sv
rtl/bsp_ctrl.sv
rtl/bounded_stack_with_palindrome_check_unit.sv
tb/tb_bounded_stack_with_palindrome_check_unit.sv
